// ----- design/imh_pkg.sv -----
package imh_pkg;

  // Sizes of the heap, the vertex space and the keys.
  localparam int unsigned HEAP_DEPTH   = 256;
  localparam int unsigned VTX_W        = 8;
  localparam int unsigned VERTEX_COUNT = 1 << VTX_W;
  localparam int unsigned WEIGHT_BITS  = 32;
  localparam int unsigned WEIGHT_IN_W  = 32;
  localparam int unsigned SLOT_W       = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W        = SLOT_W + 1;
  localparam int unsigned CAP_W        = 9;
  localparam int unsigned SLOT_BITS    = VTX_W + WEIGHT_BITS;

  // Configuration port.
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(256);

  // Operation codes.
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // One heap slot: the vertex and its key.
  typedef struct packed {
    logic [VTX_W-1:0]       vtx;
    logic [WEIGHT_BITS-1:0] key;
  } slot_t;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_POS    = 9'b000000010,
    S_UP     = 9'b000000100,
    S_UPCMP  = 9'b000001000,
    S_EXROOT = 9'b000010000,
    S_EXLAST = 9'b000100000,
    S_DN     = 9'b001000000,
    S_DNL    = 9'b010000000,
    S_DNR    = 9'b100000000
  } state_e;

endpackage

// ----- design/imh_ram.sv -----
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/indexed_min_heap_unit.sv -----
// Indexed binary min-heap with insert-or-update and extract-minimum.
// One word at a time; the receiver cannot stall. A dropped insert or an empty extract shows
// its result word on done_o in the cycle after acceptance; otherwise busy stays high during
// the sift, paced by the single read port of the slot memory (sift up reads then compares each
// parent, sift down reads the left and then the right child), and the word follows as busy falls.
// Reset clears the entry count and the vertex present bits and sets the capacity limit to 256.
module indexed_min_heap_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic [imh_pkg::VTX_W-1:0]           vertex_id_i,
  input  logic [imh_pkg::WEIGHT_IN_W-1:0]     weight_i,
  // Result channel
  output logic                                done_o,
  output logic [imh_pkg::VTX_W-1:0]           min_vertex_o,
  output logic                                was_empty_o,
  output logic                                overflow_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imh_pkg::PADDR_W-1:0]         paddr,
  input  logic [imh_pkg::PDATA_W-1:0]         pwdata,
  output logic [imh_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  imh_pkg::state_e                    state_q, state_d;
  imh_pkg::slot_t                     e_q, e_d;
  imh_pkg::slot_t                     best_q, best_d;
  logic                               bleft_q, bleft_d;
  logic [imh_pkg::SLOT_W-1:0]         i_q, i_d;
  logic [imh_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [imh_pkg::VTX_W-1:0]          root_q, root_d;
  logic [imh_pkg::CAP_W-1:0]          cap_q;
  logic [imh_pkg::VERTEX_COUNT-1:0]   present_q;
  logic                               done_q, done_d;
  logic [imh_pkg::VTX_W-1:0]          minv_q, minv_d;
  logic                               empty_q, empty_d;
  logic                               ovf_q, ovf_d;

  // Memory ports
  logic                               hw_en;
  logic [imh_pkg::SLOT_W-1:0]         hw_addr;
  imh_pkg::slot_t                     hw_data;
  logic [imh_pkg::SLOT_W-1:0]         hr_addr;
  logic [imh_pkg::SLOT_BITS-1:0]      hr_raw;
  imh_pkg::slot_t                     hr_data;
  logic                               pw_en;
  logic [imh_pkg::VTX_W-1:0]          pw_addr;
  logic [imh_pkg::SLOT_W-1:0]         pw_data;
  logic [imh_pkg::SLOT_W-1:0]         pos_rd;

  // Present bit updates
  logic                               pres_set;
  logic                               pres_clr;
  logic [imh_pkg::VTX_W-1:0]          pres_idx;

  // Index arithmetic
  logic                               full;
  logic [imh_pkg::SLOT_W-1:0]         parent;
  logic [imh_pkg::CNT_W-1:0]          left_idx;
  logic [imh_pkg::CNT_W:0]            right_idx;
  logic [imh_pkg::CNT_W-1:0]          last_idx;

  // Sift-down decision
  logic                               ch_move;
  imh_pkg::slot_t                     ch_slot;
  logic [imh_pkg::SLOT_W-1:0]         ch_idx;

  assign hr_data   = imh_pkg::slot_t'(hr_raw);
  assign full      = (cnt_q >= imh_pkg::CNT_W'(cap_q))
                  || (cnt_q >= imh_pkg::CNT_W'(imh_pkg::HEAP_DEPTH));
  assign parent    = (i_q - imh_pkg::SLOT_W'(1)) >> 1;
  assign left_idx  = {i_q, 1'b1};
  assign right_idx = {1'b0, i_q, 1'b0} + (imh_pkg::CNT_W+1)'(2);
  assign last_idx  = cnt_q - imh_pkg::CNT_W'(1);

  // Slot memory holds vertex and key of each heap slot.
  imh_ram #(
    .WIDTH(imh_pkg::SLOT_BITS),
    .DEPTH(imh_pkg::HEAP_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (hw_en),
    .waddr_i(hw_addr),
    .wdata_i(hw_data),
    .raddr_i(hr_addr),
    .rdata_o(hr_raw)
  );

  // Position memory maps a vertex to its slot; validity lives in present_q.
  imh_ram #(
    .WIDTH(imh_pkg::SLOT_W),
    .DEPTH(imh_pkg::VERTEX_COUNT)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pw_en),
    .waddr_i(pw_addr),
    .wdata_i(pw_data),
    .raddr_i(vertex_id_i),
    .rdata_o(pos_rd)
  );

  // Sift-down choice: the smaller child wins only when strictly smaller,
  // and the left child is preferred on a tie.
  always_comb begin
    ch_move = 1'b0;
    ch_slot = hr_data;
    ch_idx  = left_idx[imh_pkg::SLOT_W-1:0];
    if (state_q == imh_pkg::S_DNR) begin
      if (hr_data.key < best_q.key) begin
        ch_move = 1'b1;
        ch_slot = hr_data;
        ch_idx  = right_idx[imh_pkg::SLOT_W-1:0];
      end else if (bleft_q) begin
        ch_move = 1'b1;
        ch_slot = best_q;
      end
    end else if (hr_data.key < e_q.key) begin
      ch_move = 1'b1;
    end
  end

  // Sequencer: the moving entry stays in e_q and is written once it settles.
  always_comb begin
    state_d  = state_q;
    e_d      = e_q;
    best_d   = best_q;
    bleft_d  = bleft_q;
    i_d      = i_q;
    cnt_d    = cnt_q;
    root_d   = root_q;
    done_d   = 1'b0;
    minv_d   = minv_q;
    empty_d  = empty_q;
    ovf_d    = ovf_q;
    hw_en    = 1'b0;
    hw_addr  = i_q;
    hw_data  = e_q;
    hr_addr  = '0;
    pw_en    = 1'b0;
    pw_addr  = e_q.vtx;
    pw_data  = i_q;
    pres_set = 1'b0;
    pres_clr = 1'b0;
    pres_idx = vertex_id_i;

    case (state_q)
      imh_pkg::S_IDLE: begin
        // The root is read here so that an extract finds it next cycle.
        hr_addr = '0;
        if (start) begin
          e_d = '{vtx: vertex_id_i, key: weight_i[imh_pkg::WEIGHT_BITS-1:0]};
          if (mode_i == imh_pkg::MODE_INSERT) begin
            if (full) begin
              done_d  = 1'b1;
              minv_d  = '0;
              empty_d = 1'b0;
              ovf_d   = 1'b1;
            end else if (present_q[vertex_id_i]) begin
              state_d = imh_pkg::S_POS;
            end else begin
              i_d      = cnt_q[imh_pkg::SLOT_W-1:0];
              cnt_d    = cnt_q + imh_pkg::CNT_W'(1);
              pres_set = 1'b1;
              state_d  = imh_pkg::S_UP;
            end
          end else if (cnt_q == '0) begin
            done_d  = 1'b1;
            minv_d  = '0;
            empty_d = 1'b1;
            ovf_d   = 1'b0;
          end else begin
            state_d = imh_pkg::S_EXROOT;
          end
        end
      end

      imh_pkg::S_POS: begin
        // An update starts sifting up from the vertex's current slot.
        if ({1'b0, pos_rd} >= cnt_q) begin
          done_d  = 1'b1;
          minv_d  = '0;
          empty_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = imh_pkg::S_IDLE;
        end else begin
          i_d     = pos_rd;
          state_d = imh_pkg::S_UP;
        end
      end

      imh_pkg::S_UP: begin
        if (i_q == '0) begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          done_d  = 1'b1;
          minv_d  = '0;
          empty_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = imh_pkg::S_IDLE;
        end else begin
          hr_addr = parent;
          state_d = imh_pkg::S_UPCMP;
        end
      end

      imh_pkg::S_UPCMP: begin
        // A strictly greater parent moves down into the hole.
        if (hr_data.key > e_q.key) begin
          hw_en   = 1'b1;
          hw_data = hr_data;
          pw_en   = 1'b1;
          pw_addr = hr_data.vtx;
          i_d     = parent;
          state_d = imh_pkg::S_UP;
        end else begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          done_d  = 1'b1;
          minv_d  = '0;
          empty_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = imh_pkg::S_IDLE;
        end
      end

      imh_pkg::S_EXROOT: begin
        // Root is out; fetch the last entry to refill the root.
        root_d   = hr_data.vtx;
        pres_clr = 1'b1;
        pres_idx = hr_data.vtx;
        cnt_d    = last_idx;
        hr_addr  = last_idx[imh_pkg::SLOT_W-1:0];
        state_d  = imh_pkg::S_EXLAST;
      end

      imh_pkg::S_EXLAST: begin
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          minv_d  = root_q;
          empty_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = imh_pkg::S_IDLE;
        end else begin
          e_d     = hr_data;
          i_d     = '0;
          state_d = imh_pkg::S_DN;
        end
      end

      imh_pkg::S_DN: begin
        if (left_idx >= cnt_q) begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          done_d  = 1'b1;
          minv_d  = root_q;
          empty_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = imh_pkg::S_IDLE;
        end else begin
          hr_addr = left_idx[imh_pkg::SLOT_W-1:0];
          state_d = imh_pkg::S_DNL;
        end
      end

      imh_pkg::S_DNL, imh_pkg::S_DNR: begin
        if ((state_q == imh_pkg::S_DNL) && (right_idx < {1'b0, cnt_q})) begin
          // Keep the better of the entry and the left child, then read right.
          best_d  = ch_move ? hr_data : e_q;
          bleft_d = ch_move;
          hr_addr = right_idx[imh_pkg::SLOT_W-1:0];
          state_d = imh_pkg::S_DNR;
        end else if (ch_move) begin
          hw_en   = 1'b1;
          hw_data = ch_slot;
          pw_en   = 1'b1;
          pw_addr = ch_slot.vtx;
          i_d     = ch_idx;
          state_d = imh_pkg::S_DN;
        end else begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          done_d  = 1'b1;
          minv_d  = root_q;
          empty_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = imh_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = imh_pkg::S_IDLE;
      end
    endcase
  end

  // Control state, entry count and done flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imh_pkg::S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Working payload needs no reset.
  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    best_q  <= best_d;
    bleft_q <= bleft_d;
    i_q     <= i_d;
    root_q  <= root_d;
    minv_q  <= minv_d;
    empty_q <= empty_d;
    ovf_q   <= ovf_d;
  end

  // Present bit of each vertex, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (pres_set) begin
      present_q[pres_idx] <= 1'b1;
    end else if (pres_clr) begin
      present_q[pres_idx] <= 1'b0;
    end
  end

  // Capacity limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= imh_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite
                 && (paddr[imh_pkg::PADDR_W-1:2] == imh_pkg::REG_CAPACITY)) begin
      cap_q <= pwdata[imh_pkg::CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[imh_pkg::PADDR_W-1:2] == imh_pkg::REG_CAPACITY)
                ? imh_pkg::PDATA_W'(cap_q) : '0;

  assign busy         = (state_q != imh_pkg::S_IDLE);
  assign done_o       = done_q;
  assign min_vertex_o = minv_q;
  assign was_empty_o  = empty_q;
  assign overflow_o   = ovf_q;

endmodule

// ----- sim/indexed_min_heap_unit_tb.sv -----
module indexed_min_heap_unit_tb;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [imh_pkg::VTX_W-1:0] min_vertex;
    logic                      was_empty;
    logic                      overflow;
  } outcome_t;

  // One row of the directed script: either a command word or a capacity write.
  typedef struct packed {
    logic                            is_cfg;
    logic                            mode;
    logic [imh_pkg::VTX_W-1:0]       vtx;
    logic [imh_pkg::WEIGHT_IN_W-1:0] wgt;
    logic [imh_pkg::CAP_W-1:0]       cap;
    logic                            fixed;
    outcome_t                        want;
  } script_row_t;

  localparam int unsigned SCRIPT_ROWS = 32;
  localparam logic [imh_pkg::PADDR_W-1:0] CAP_ADDR = {imh_pkg::REG_CAPACITY, 2'b00};

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic                            mode_i;
  logic [imh_pkg::VTX_W-1:0]       vertex_id_i;
  logic [imh_pkg::WEIGHT_IN_W-1:0] weight_i;
  logic                            done_o;
  logic [imh_pkg::VTX_W-1:0]       min_vertex_o;
  logic                            was_empty_o;
  logic                            overflow_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [imh_pkg::PADDR_W-1:0]     paddr;
  logic [imh_pkg::PDATA_W-1:0]     pwdata;
  logic [imh_pkg::PDATA_W-1:0]     prdata;
  logic                            pready;

  // Shadow copy of the heap, the position table and the capacity register.
  logic [imh_pkg::VTX_W-1:0]       heap_vtx [imh_pkg::HEAP_DEPTH];
  logic [imh_pkg::WEIGHT_BITS-1:0] heap_key [imh_pkg::HEAP_DEPTH];
  int unsigned                     heap_size = 0;
  int unsigned                     vtx_slot [imh_pkg::VERTEX_COUNT];
  bit                              vtx_here [imh_pkg::VERTEX_COUNT];
  logic [imh_pkg::CAP_W-1:0]       cap_limit = imh_pkg::CAPACITY_RESET;

  outcome_t    pending_outcomes [$];
  script_row_t directed_script [SCRIPT_ROWS];
  int unsigned error_count = 0;
  int unsigned n_insert = 0;
  int unsigned n_full = 0;
  int unsigned n_extract = 0;
  int unsigned n_empty = 0;
  int unsigned cfg_count = 0;

  indexed_min_heap_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .vertex_id_i  (vertex_id_i),
    .weight_i     (weight_i),
    .done_o       (done_o),
    .min_vertex_o (min_vertex_o),
    .was_empty_o  (was_empty_o),
    .overflow_o   (overflow_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #600000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Swap two slots and keep the position table in step.
  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [imh_pkg::VTX_W-1:0]       tv;
    logic [imh_pkg::WEIGHT_BITS-1:0] tk;
    tv = heap_vtx[a];
    tk = heap_key[a];
    heap_vtx[a] = heap_vtx[b];
    heap_key[a] = heap_key[b];
    heap_vtx[b] = tv;
    heap_key[b] = tk;
    vtx_slot[heap_vtx[a]] = a;
    vtx_slot[heap_vtx[b]] = b;
  endfunction

  // Move an entry up while its parent is strictly heavier.
  function automatic void sift_toward_root(input int unsigned start_idx);
    int unsigned i;
    int unsigned p;
    i = start_idx;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(heap_key[p] > heap_key[i])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  // Move an entry down towards the strictly lighter child, left winning ties.
  function automatic void sift_toward_leaves(input int unsigned start_idx);
    int unsigned i;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    i = start_idx;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      best = i;
      if (l < heap_size && heap_key[l] < heap_key[best]) best = l;
      if (r < heap_size && heap_key[r] < heap_key[best]) best = r;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  // Apply one command word to the shadow heap and return the word the block owes.
  function automatic outcome_t apply_heap_op(input logic mode,
                                             input logic [imh_pkg::VTX_W-1:0] v,
                                             input logic [imh_pkg::WEIGHT_IN_W-1:0] w);
    outcome_t                  res;
    int unsigned               eff;
    int unsigned               idx;
    logic [imh_pkg::VTX_W-1:0] root;
    res = '0;
    eff = (cap_limit < imh_pkg::HEAP_DEPTH) ? cap_limit : imh_pkg::HEAP_DEPTH;
    if (mode == imh_pkg::MODE_INSERT) begin
      n_insert++;
      // A full heap drops the word, even an update of a vertex already held.
      if (heap_size >= eff) begin
        res.overflow = 1'b1;
        n_full++;
        return res;
      end
      if (!vtx_here[v]) begin
        idx = heap_size;
        heap_size++;
        heap_vtx[idx] = v;
        heap_key[idx] = w[imh_pkg::WEIGHT_BITS-1:0];
        vtx_here[v] = 1'b1;
        vtx_slot[v] = idx;
      end else begin
        idx = vtx_slot[v];
        heap_key[idx] = w[imh_pkg::WEIGHT_BITS-1:0];
      end
      // An update only ever sifts up, even when the weight was raised.
      sift_toward_root(idx);
    end else begin
      n_extract++;
      if (heap_size == 0) begin
        res.was_empty = 1'b1;
        n_empty++;
        return res;
      end
      root = heap_vtx[0];
      vtx_here[root] = 1'b0;
      heap_size--;
      // The last entry takes the root and its position is refreshed first.
      if (heap_size > 0) begin
        heap_vtx[0] = heap_vtx[heap_size];
        heap_key[0] = heap_key[heap_size];
        vtx_slot[heap_vtx[0]] = 0;
        sift_toward_leaves(0);
      end
      res.min_vertex = root;
    end
    return res;
  endfunction

  function automatic script_row_t cmd_row(input logic mode,
                                          input logic [imh_pkg::VTX_W-1:0] v,
                                          input logic [imh_pkg::WEIGHT_IN_W-1:0] w);
    script_row_t row;
    row = '0;
    row.mode = mode;
    row.vtx = v;
    row.wgt = w;
    return row;
  endfunction

  function automatic script_row_t fixed_row(input logic mode,
                                            input logic [imh_pkg::VTX_W-1:0] v,
                                            input logic [imh_pkg::WEIGHT_IN_W-1:0] w,
                                            input logic [imh_pkg::VTX_W-1:0] want_min,
                                            input logic want_empty, input logic want_ovf);
    script_row_t row;
    row = cmd_row(mode, v, w);
    row.fixed = 1'b1;
    row.want = '{min_vertex: want_min, was_empty: want_empty, overflow: want_ovf};
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [imh_pkg::CAP_W-1:0] cap);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  // Present one command word and hold it until the block takes it.
  task automatic issue_cmd(input logic mode, input logic [imh_pkg::VTX_W-1:0] v,
                           input logic [imh_pkg::WEIGHT_IN_W-1:0] w, input bit fixed,
                           input outcome_t fixed_want);
    outcome_t predicted;
    @(negedge clk_i);
    start = 1'b1;
    mode_i = mode;
    vertex_id_i = v;
    weight_i = w;
    do @(posedge clk_i); while (busy);
    predicted = apply_heap_op(mode, v, w);
    pending_outcomes.push_back(fixed ? fixed_want : predicted);
  endtask

  // Leave the command channel idle for a number of cycles, with noise on the fields.
  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start = 1'b0;
    mode_i = 1'($urandom);
    vertex_id_i = imh_pkg::VTX_W'($urandom);
    weight_i = $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop issuing and wait until every owed word has come back.
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0 || busy);
  endtask

  task automatic apb_read_check(input logic [imh_pkg::CAP_W-1:0] want);
    logic [imh_pkg::PDATA_W-1:0] got;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = CAP_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got != imh_pkg::PDATA_W'(want))
      report_mismatch($sformatf("capacity read back %0d expected %0d", got, want));
  endtask

  // Write the capacity register while the block is idle, then read it back.
  task automatic set_capacity(input logic [imh_pkg::CAP_W-1:0] value);
    settle();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CAP_ADDR;
    pwdata = imh_pkg::PDATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_limit = value;
    cfg_count++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    apb_read_check(value);
  endtask

  // Compare every result word with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (min_vertex_o !== want.min_vertex)
          report_mismatch($sformatf("min_vertex got %0d expected %0d",
                                    min_vertex_o, want.min_vertex));
        if (was_empty_o !== want.was_empty)
          report_mismatch($sformatf("was_empty got %b expected %b",
                                    was_empty_o, want.was_empty));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow got %b expected %b",
                                    overflow_o, want.overflow));
      end
    end
  end

  initial begin
    script_row_t                     row;
    int unsigned                     stage_idx;
    int unsigned                     stage_len;
    int unsigned                     ins_pct;
    bit                              idle_ok;
    logic [imh_pkg::CAP_W-1:0]       stage_cap;
    logic                            mode;
    logic [imh_pkg::VTX_W-1:0]       v;
    logic [imh_pkg::WEIGHT_IN_W-1:0] w;

    start = 1'b0;
    mode_i = imh_pkg::MODE_INSERT;
    vertex_id_i = '0;
    weight_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;

    // Directed script: empty heap, extreme keys and vertices, ties, decrease and
    // raise of a held key, a full heap (also for an update), a zero limit, a limit
    // lowered below the fill level and a limit above the heap depth.
    directed_script = '{
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd0, 1'b1, 1'b0),
      fixed_row(imh_pkg::MODE_INSERT, 8'd0, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0),
      fixed_row(imh_pkg::MODE_INSERT, 8'd255, 32'h0000_0000, 8'd0, 1'b0, 1'b0),
      cmd_row(imh_pkg::MODE_INSERT, 8'd128, 32'h0001_0000),
      cmd_row(imh_pkg::MODE_INSERT, 8'd7, 32'h0001_0000),
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd255, 1'b0, 1'b0),
      cmd_row(imh_pkg::MODE_INSERT, 8'd0, 32'h0000_0000),
      cmd_row(imh_pkg::MODE_INSERT, 8'd128, 32'hFFFF_FFFF),
      cmd_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0),
      cmd_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0),
      cmd_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0),
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd0, 1'b1, 1'b0),
      cfg_row(9'd1),
      cmd_row(imh_pkg::MODE_INSERT, 8'd3, 32'hAAAA_5555),
      fixed_row(imh_pkg::MODE_INSERT, 8'd4, 32'h5555_AAAA, 8'd0, 1'b0, 1'b1),
      fixed_row(imh_pkg::MODE_INSERT, 8'd3, 32'h0000_0000, 8'd0, 1'b0, 1'b1),
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd3, 1'b0, 1'b0),
      cfg_row(9'd0),
      fixed_row(imh_pkg::MODE_INSERT, 8'd1, 32'd1, 8'd0, 1'b0, 1'b1),
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd0, 1'b1, 1'b0),
      cfg_row(9'd256),
      cmd_row(imh_pkg::MODE_INSERT, 8'd10, 32'd30),
      cmd_row(imh_pkg::MODE_INSERT, 8'd11, 32'd20),
      cmd_row(imh_pkg::MODE_INSERT, 8'd12, 32'd10),
      cfg_row(9'd2),
      fixed_row(imh_pkg::MODE_INSERT, 8'd13, 32'd0, 8'd0, 1'b0, 1'b1),
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd12, 1'b0, 1'b0),
      cfg_row(9'd511),
      cmd_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0),
      cmd_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0),
      fixed_row(imh_pkg::MODE_EXTRACT, 8'd0, 32'd0, 8'd0, 1'b1, 1'b0),
      cfg_row(9'd256)
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    apb_read_check(imh_pkg::CAPACITY_RESET);

    // Walk the directed script, with the odd gap between words.
    foreach (directed_script[i]) begin
      row = directed_script[i];
      if (row.is_cfg) begin
        set_capacity(row.cap);
      end else begin
        issue_cmd(row.mode, row.vtx, row.wgt, row.fixed, row.want);
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
      end
    end

    // Random stages: each sets a capacity and a mix of inserts and extracts, so
    // the heap fills deep, drains, overflows at small limits and runs past a
    // limit lowered under its fill level. The last stage runs without gaps.
    for (stage_idx = 0; stage_idx < 8; stage_idx++) begin
      idle_ok = 1'b1;
      case (stage_idx)
        0: begin stage_cap = 9'd256; ins_pct = 60; stage_len = 80; end
        1: begin
          stage_cap = imh_pkg::CAP_W'($urandom_range(2, 12)); ins_pct = 55; stage_len = 80;
        end
        2: begin stage_cap = 9'd256; ins_pct = 90; stage_len = 120; end
        3: begin
          stage_cap = imh_pkg::CAP_W'($urandom_range(1, 256)); ins_pct = 50; stage_len = 80;
        end
        4: begin stage_cap = 9'd511; ins_pct = 30; stage_len = 90; end
        5: begin
          stage_cap = imh_pkg::CAP_W'($urandom_range(1, 8)); ins_pct = 40; stage_len = 60;
        end
        6: begin stage_cap = 9'd256; ins_pct = 65; stage_len = 70; end
        default: begin
          stage_cap = 9'd256;
          ins_pct = 50;
          stage_len = 70;
          idle_ok = 1'b0;
        end
      endcase
      set_capacity(stage_cap);
      repeat (stage_len) begin
        mode = ($urandom_range(1, 100) <= ins_pct) ? imh_pkg::MODE_INSERT
                                                   : imh_pkg::MODE_EXTRACT;
        // A small pool of vertices makes updates of held entries common.
        v = ($urandom_range(0, 2) == 0) ? imh_pkg::VTX_W'($urandom_range(0, 15))
                                        : imh_pkg::VTX_W'($urandom);
        case ($urandom_range(0, 5))
          0: w = $urandom_range(0, 7);
          1: w = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: w = $urandom;
        endcase
        issue_cmd(mode, v, w, 1'b0, '0);
        if (idle_ok && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_outcomes.size()));

    $display("Ran %0d inserts (%0d dropped on a full heap) and %0d extracts (%0d on an empty heap)",
             n_insert, n_full, n_extract, n_empty);
    $display("across %0d capacity settings, with %0d mismatches.", cfg_count, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
